// ===== hdl/iasp_pkg.sv =====
// ----------------------------------------------------------------------------
// iasp_pkg
// Shared types and constants for the indexed animation stream parser.
// ----------------------------------------------------------------------------
package iasp_pkg;

  localparam int unsigned IASP_QUEUE_DEPTH = 2;

  localparam logic [7:0] MAGIC_D     = 8'h44;
  localparam logic [7:0] MAGIC_G     = 8'h47;
  localparam logic [7:0] MAGIC_F     = 8'h46;
  localparam logic [7:0] VERSION_BYTE = 8'h11;
  localparam logic [1:0] MODE_6BIT   = 2'd3;
  localparam logic [3:0] DISP_SHIFT  = 4'd2;

  localparam logic [24:0] ERR_MAGIC   = 25'd0;
  localparam logic [24:0] ERR_VERSION = 25'd1;
  localparam logic [24:0] ERR_MARKER  = 25'd2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_MG, PH_MF, PH_VER, PH_WID, PH_HGT, PH_CINFO, PH_PR, PH_PG, PH_PB,
    PH_MARK, PH_DHI, PH_DLO, PH_FX, PH_FY, PH_FW, PH_FH, PH_TR, PH_DISP, PH_SHX,
    PH_SHY, PH_PIX, PH_NEXT
  } phase_t;

  typedef enum logic [4:0] {
    K_CANVAS_W   = 5'd0,
    K_CANVAS_H   = 5'd1,
    K_COUNT      = 5'd2,
    K_PALETTE    = 5'd3,
    K_DURATION   = 5'd4,
    K_X          = 5'd5,
    K_Y          = 5'd6,
    K_W          = 5'd7,
    K_H          = 5'd8,
    K_TR_TYPE    = 5'd9,
    K_TR_INDEX   = 5'd10,
    K_DISPOSAL   = 5'd11,
    K_DISP_PARAM = 5'd12,
    K_SHIFT_X    = 5'd13,
    K_SHIFT_Y    = 5'd14,
    K_PIXEL      = 5'd15,
    K_END        = 5'd16,
    K_ERROR      = 5'd17
  } kind_t;

  // One classified input byte: up to two ready-made results, or a byte of
  // packed 1/2/4-bit pixels that the back end unpacks.
  typedef struct packed {
    logic [3:0]  cnt;
    logic        unpack;
    logic [1:0]  mode;
    logic [7:0]  data;
    kind_t       kind0;
    logic [24:0] value0;
    kind_t       kind1;
    logic [24:0] value1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/iasp_front.sv =====
// ----------------------------------------------------------------------------
// iasp_front
// Header and frame parser: takes one byte per cycle while the queue is not
// full and turns it into a command for the result queue.
// ----------------------------------------------------------------------------
module iasp_front import iasp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_frame_marker,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_image,
  input  q_stat_t    q_stat,
  output logic       push,
  output cmd_t       cmd
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [6:0]  pal_left_r, pal_left_nxt;
  logic [15:0] held_r, held_nxt;
  logic [7:0]  fw_r, fw_nxt;
  logic [15:0] pix_left_r, pix_left_nxt;
  logic [1:0]  pix_phase_r, pix_phase_nxt;
  logic [5:0]  carry_r, carry_nxt;
  logic [7:0]  marker_r;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] area;
  logic [3:0]  per_byte;
  logic [3:0]  avail;
  logic [15:0] pix_dec;
  logic [6:0]  pal_dec;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data_byte;
  assign area     = 16'(fw_r) * 16'(b);
  assign per_byte = 4'd8 >> mode_r;
  assign avail    = (pix_left_r < {12'd0, per_byte}) ? pix_left_r[3:0] : per_byte;
  assign pal_dec  = pal_left_r - 7'd1;
  assign push     = accept && (cmd.cnt != 4'd0);

  always_comb begin
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    pal_left_nxt  = pal_left_r;
    held_nxt      = held_r;
    fw_nxt        = fw_r;
    pix_left_nxt  = pix_left_r;
    pix_phase_nxt = pix_phase_r;
    carry_nxt     = carry_r;
    pix_dec       = 16'd0;
    cmd           = '0;
    cmd.kind0     = K_ERROR;
    cmd.kind1     = K_PIXEL;
    if (accept) begin
      if (in_start_image) begin
        if (b == MAGIC_D) begin
          phase_nxt = PH_MG;
        end else begin
          cmd.cnt   = 4'd1;
          cmd.kind0 = K_ERROR;
          cmd.value0 = ERR_MAGIC;
          phase_nxt = PH_IDLE;
        end
      end else begin
        unique case (phase_r)
          PH_MG, PH_MF: begin
            if (b == ((phase_r == PH_MG) ? MAGIC_G : MAGIC_F)) begin
              phase_nxt = (phase_r == PH_MG) ? PH_MF : PH_VER;
            end else begin
              cmd.cnt    = 4'd1;
              cmd.value0 = ERR_MAGIC;
              phase_nxt  = PH_IDLE;
            end
          end
          PH_VER: begin
            if (b == VERSION_BYTE) begin
              phase_nxt = PH_WID;
            end else begin
              cmd.cnt    = 4'd1;
              cmd.value0 = ERR_VERSION;
              phase_nxt  = PH_IDLE;
            end
          end
          PH_WID: begin
            cmd.cnt    = 4'd1;
            cmd.kind0  = K_CANVAS_W;
            cmd.value0 = {17'd0, b};
            phase_nxt  = PH_HGT;
          end
          PH_HGT: begin
            cmd.cnt    = 4'd1;
            cmd.kind0  = K_CANVAS_H;
            cmd.value0 = {17'd0, b};
            phase_nxt  = PH_CINFO;
          end
          PH_CINFO: begin
            mode_nxt     = b[7:6];
            pal_left_nxt = {1'b0, b[5:0]} + 7'd1;
            cmd.cnt      = 4'd1;
            cmd.kind0    = K_COUNT;
            cmd.value0   = {18'd0, pal_left_nxt};
            phase_nxt    = PH_PR;
          end
          PH_PR: begin
            held_nxt  = {b, 8'd0};
            phase_nxt = PH_PG;
          end
          PH_PG: begin
            held_nxt  = {held_r[15:8], b};
            phase_nxt = PH_PB;
          end
          PH_PB: begin
            cmd.cnt      = 4'd1;
            cmd.kind0    = K_PALETTE;
            cmd.value0   = {1'b0, held_r, b};
            pal_left_nxt = pal_dec;
            phase_nxt    = (pal_dec == 7'd0) ? PH_MARK : PH_PR;
          end
          PH_MARK, PH_NEXT: begin
            if (b == marker_r) begin
              phase_nxt = PH_DHI;
            end else begin
              cmd.cnt    = 4'd1;
              cmd.kind0  = (phase_r == PH_MARK) ? K_ERROR : K_END;
              cmd.value0 = (phase_r == PH_MARK) ? ERR_MARKER : 25'd0;
              phase_nxt  = PH_IDLE;
            end
          end
          PH_DHI: begin
            held_nxt  = {8'd0, b};
            phase_nxt = PH_DLO;
          end
          PH_DLO: begin
            cmd.cnt    = 4'd1;
            cmd.kind0  = K_DURATION;
            cmd.value0 = {9'd0, held_r[7:0], b};
            phase_nxt  = PH_FX;
          end
          PH_FX: begin
            cmd.cnt    = 4'd1;
            cmd.kind0  = K_X;
            cmd.value0 = {17'd0, b};
            phase_nxt  = PH_FY;
          end
          PH_FY: begin
            cmd.cnt    = 4'd1;
            cmd.kind0  = K_Y;
            cmd.value0 = {17'd0, b};
            phase_nxt  = PH_FW;
          end
          PH_FW: begin
            cmd.cnt    = 4'd1;
            cmd.kind0  = K_W;
            cmd.value0 = {17'd0, b};
            fw_nxt     = b;
            phase_nxt  = PH_FH;
          end
          PH_FH: begin
            cmd.cnt      = 4'd1;
            cmd.kind0    = K_H;
            cmd.value0   = {17'd0, b};
            pix_left_nxt = area;
            phase_nxt    = PH_TR;
          end
          PH_TR: begin
            cmd.cnt    = 4'd2;
            cmd.kind0  = K_TR_TYPE;
            cmd.value0 = {23'd0, b[7:6]};
            cmd.kind1  = K_TR_INDEX;
            cmd.value1 = {19'd0, b[5:0]};
            phase_nxt  = PH_DISP;
          end
          PH_DISP: begin
            cmd.cnt    = 4'd2;
            cmd.kind0  = K_DISPOSAL;
            cmd.value0 = {21'd0, b[7:4]};
            cmd.kind1  = K_DISP_PARAM;
            cmd.value1 = {21'd0, b[3:0]};
            if (b[7:4] == DISP_SHIFT) begin
              phase_nxt = PH_SHX;
            end else begin
              pix_phase_nxt = 2'd0;
              carry_nxt     = 6'd0;
              phase_nxt     = (pix_left_r == 16'd0) ? PH_NEXT : PH_PIX;
            end
          end
          PH_SHX: begin
            cmd.cnt    = 4'd1;
            cmd.kind0  = K_SHIFT_X;
            cmd.value0 = {{17{b[7]}}, b};
            phase_nxt  = PH_SHY;
          end
          PH_SHY: begin
            cmd.cnt       = 4'd1;
            cmd.kind0     = K_SHIFT_Y;
            cmd.value0    = {{17{b[7]}}, b};
            pix_phase_nxt = 2'd0;
            carry_nxt     = 6'd0;
            phase_nxt     = (pix_left_r == 16'd0) ? PH_NEXT : PH_PIX;
          end
          PH_PIX: begin
            cmd.kind0 = K_PIXEL;
            if (mode_r == MODE_6BIT) begin
              cmd.cnt = 4'd1;
              pix_dec = 16'd1;
              unique case (pix_phase_r)
                2'd1: begin
                  cmd.value0    = {19'd0, carry_r[5:4], b[7:4]};
                  carry_nxt     = {b[3:0], 2'b00};
                  pix_phase_nxt = 2'd2;
                end
                2'd2: begin
                  cmd.value0    = {19'd0, carry_r[5:2], b[7:6]};
                  carry_nxt     = b[5:0];
                  pix_phase_nxt = 2'd0;
                  // second pixel of the group only when it is still due
                  if (pix_left_r >= 16'd2) begin
                    cmd.cnt    = 4'd2;
                    cmd.value1 = {19'd0, b[5:0]};
                    pix_dec    = 16'd2;
                  end
                end
                default: begin
                  cmd.value0    = {19'd0, b[7:2]};
                  carry_nxt     = {b[1:0], 4'd0};
                  pix_phase_nxt = 2'd1;
                end
              endcase
            end else begin
              cmd.cnt    = avail;
              cmd.unpack = 1'b1;
              cmd.mode   = mode_r;
              cmd.data   = b;
              pix_dec    = {12'd0, avail};
            end
            pix_left_nxt = pix_left_r - pix_dec;
            if (pix_left_nxt == 16'd0) begin
              phase_nxt = PH_NEXT;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      mode_r      <= 2'd0;
      pal_left_r  <= 7'd0;
      held_r      <= 16'd0;
      fw_r        <= 8'd0;
      pix_left_r  <= 16'd0;
      pix_phase_r <= 2'd0;
      carry_r     <= 6'd0;
      marker_r    <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      pal_left_r  <= pal_left_nxt;
      held_r      <= held_nxt;
      fw_r        <= fw_nxt;
      pix_left_r  <= pix_left_nxt;
      pix_phase_r <= pix_phase_nxt;
      carry_r     <= carry_nxt;
      if (cfg_valid) begin
        marker_r <= cfg_frame_marker;
      end
    end
  end

endmodule

// ===== hdl/iasp_queue.sv =====
// ----------------------------------------------------------------------------
// iasp_queue
// Short command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module iasp_queue import iasp_pkg::*; #(
  parameter int unsigned DEPTH = IASP_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/iasp_back.sv =====
// ----------------------------------------------------------------------------
// iasp_back
// Result sequencer: steps through the head command one result per cycle,
// while the output register is free or being read, into the output register.
// ----------------------------------------------------------------------------
module iasp_back import iasp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               head,
  input  q_stat_t            q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_kind,
  output logic signed [24:0] out_value,
  output logic               out_last_result
);

  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r;
  logic [24:0] value_r;
  logic        last_r;
  logic [2:0]  idx_r, idx_nxt;

  logic        fire;
  logic        last;
  logic [2:0]  shamt;
  logic [7:0]  shifted;
  logic [24:0] pix_val;
  kind_t       res_kind;
  logic [24:0] res_value;

  assign fire    = !q_stat.empty && (!out_valid_r || out_ready);
  assign last    = (({1'b0, idx_r} + 4'd1) == head.cnt);
  assign pop     = fire && last;
  assign shamt   = idx_r << head.mode;
  assign shifted = head.data << shamt;

  always_comb begin
    unique case (head.mode)
      2'd0:    pix_val = {24'd0, shifted[7]};
      2'd1:    pix_val = {23'd0, shifted[7:6]};
      default: pix_val = {21'd0, shifted[7:4]};
    endcase
    if (head.unpack) begin
      res_kind  = K_PIXEL;
      res_value = pix_val;
    end else if (idx_r[0]) begin
      res_kind  = head.kind1;
      res_value = head.value1;
    end else begin
      res_kind  = head.kind0;
      res_value = head.value0;
    end
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last ? 3'd0 : idx_r + 3'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r  <= res_kind;
      value_r <= res_value;
      last_r  <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_value       = value_r;
  assign out_last_result = last_r;

endmodule

// ===== hdl/indexed_animation_stream_parser.sv =====
// ----------------------------------------------------------------------------
// indexed_animation_stream_parser
// Byte-serial parser for indexed-color animation images.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one image byte per request, with in_start_image set
//   on the first magic letter. Result channel (out_*): one (kind, value) pair
//   per request, out_last_result marking the final result of an input byte.
//   Configuration channel (cfg_*): frame marker byte, always ready; write it
//   while the block is idle.
//   A byte's first result passes the command queue, then the output register,
//   when the result path is free. Bytes with no result leave no trace
//   downstream. Throughput: one byte per cycle while the queue has room, one
//   result per cycle while the receiver is ready. A byte gives up to eight
//   results (at 1 bit per pixel), all through the single output register;
//   the command queue lets the parser run ahead.
//   Reset clears parser state, the queue and the output register; the frame
//   marker returns to 0. When the receiver stalls, the output holds, the
//   queue fills, and in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module indexed_animation_stream_parser import iasp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = IASP_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_frame_marker,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_image,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_kind,
  output logic signed [24:0] out_value,
  output logic               out_last_result
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head;

  assign cfg_ready = 1'b1;

  iasp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_frame_marker (cfg_frame_marker),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_image   (in_start_image),
    .q_stat           (q_stat),
    .push             (push),
    .cmd              (push_cmd)
  );

  iasp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  iasp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_last_result (out_last_result)
  );

  // error and end each stand alone for their byte
  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_ERROR) |-> out_last_result)
    else $error("error result not last of its byte");

  a_end_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_END) |-> out_last_result && (out_value == 25'sd0))
    else $error("end result malformed");

  // transparency type is always followed by its index from the same byte
  a_tr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_TR_TYPE) |-> !out_last_result)
    else $error("transparency type ended its byte");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("state not clean after reset");

  a_queue_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule
